// File: src/pps_pkg.sv
// ----------------------------------------------------------------------------
// Pure pursuit steering package
// Shared types, constants and the CORDIC angle table of the steering block.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int MAX_POINTS   = 256;
   localparam int ADDR_W       = $clog2(MAX_POINTS);
   localparam int CNT_W        = $clog2(MAX_POINTS + 1);
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int MIN_POINTS   = 2;
   localparam int TGT_W        = 8;
   localparam int STEER_W      = 14;
   localparam int V_W          = 60;
   localparam int Z_W          = 36;
   localparam int M_W          = 48;
   localparam int Q_W          = 31;
   localparam int DIV_STEPS    = 31;

   localparam logic signed [16:0] ANG_PI      = 17'sd12868;
   localparam logic signed [16:0] ANG_HALF_PI = 17'sd6434;
   localparam logic signed [16:0] ANG_TWO_PI  = 17'sd25736;
   localparam logic [15:0]        INV_GAIN    = 16'd39796;
   localparam logic [47:0]        ONE_Q24     = 48'd16777216;
   localparam logic signed [Z_W-1:0] ROUND_HALF = 36'sd131072;
   localparam logic signed [Z_W-1:0] STEER_MAX  = 36'sd6434;

   localparam logic CSR_WHEELBASE = 1'b0;
   localparam logic CSR_SPEED     = 1'b1;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_RESTART,
      OP_POSE
   } op_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [13:0] angle;
      logic               flip;
   } item_type;

   typedef struct packed {
      logic [15:0] wheelbase;
      logic [15:0] speed;
   } cfg_type;

   typedef struct packed {
      logic signed [STEER_W-1:0] steer;
      logic [15:0]               speed;
      logic [TGT_W-1:0]          tgt;
   } result_type;

   typedef struct packed {
      logic             busy;
      logic [CNT_W-1:0] count;
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_SCAN, S_TGT, S_OFFS, S_ROT, S_ML, S_MH, S_ME, S_VEC,
      S_CHK, S_NORM, S_DIV, S_NUM, S_ATN0, S_ATAN, S_RND, S_OUT
   } back_state_type;

   typedef enum logic [1:0] {
      MS_XE, MS_YE, MS_D
   } mul_sel_type;

   function automatic logic signed [Z_W-1:0] atan_step(input logic [STEP_W-1:0] i);
      logic signed [Z_W-1:0] v;
      case (i)
         0:       v = 36'sd843314857;
         1:       v = 36'sd497837829;
         2:       v = 36'sd263043837;
         3:       v = 36'sd133525159;
         4:       v = 36'sd67021687;
         5:       v = 36'sd33543516;
         6:       v = 36'sd16775851;
         7:       v = 36'sd8388437;
         8:       v = 36'sd4194283;
         9:       v = 36'sd2097149;
         10:      v = 36'sd1048576;
         default: v = (int'(i) <= 30) ? (Z_W'(1) <<< (30 - int'(i))) : '0;
      endcase
      return v;
   endfunction

endpackage

// File: src/pps_front.sv
// ----------------------------------------------------------------------------
// Pure pursuit front end
// Classifies incoming items and folds the heading into a rotation angle.
// ----------------------------------------------------------------------------
module pps_front import pps_pkg::*; (
   input  logic        req_type,
   input  logic        req_path_first,
   input  logic [31:0] req_coord_x,
   input  logic [31:0] req_coord_y,
   input  logic [15:0] req_heading,
   output item_type    item
);

   logic signed [16:0] a0;
   logic signed [16:0] a1;
   logic signed [16:0] a2;
   logic               flip;
   op_type             op;

   always_comb begin
      a0 = -$signed({req_heading[15], req_heading});
      if (a0 > ANG_PI) begin
         a1 = a0 - ANG_TWO_PI;
      end else if (a0 <= -ANG_PI) begin
         a1 = a0 + ANG_TWO_PI;
      end else begin
         a1 = a0;
      end
      flip = 1'b0;
      a2   = a1;
      if (a1 > ANG_HALF_PI) begin
         a2   = a1 - ANG_PI;
         flip = 1'b1;
      end else if (a1 < -ANG_HALF_PI) begin
         a2   = a1 + ANG_PI;
         flip = 1'b1;
      end
      unique case (req_type)
         1'b0:    op = req_path_first ? OP_RESTART : OP_LOAD;
         default: op = OP_POSE;
      endcase
      item.op    = op;
      item.x     = $signed(req_coord_x);
      item.y     = $signed(req_coord_y);
      item.angle = a2[13:0];
      item.flip  = flip;
   end

endmodule

// File: src/pps_queue.sv
// ----------------------------------------------------------------------------
// Pure pursuit item queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pps_queue import pps_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type pop_item,
   output logic     full,
   output logic     empty
);

   item_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: src/pps_back.sv
// ----------------------------------------------------------------------------
// Pure pursuit back end
// Waypoint store, nearest point scan, CORDIC unit, divider and result register.
// ----------------------------------------------------------------------------
module pps_back import pps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  item_type   q_item,
   input  logic       q_empty,
   output logic       q_pop,
   input  logic       rsp_pop,
   output result_type result,
   output logic       result_valid,
   output status_type status
);

   back_state_type    state_ff, state_in;
   item_type          item_ff, item_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic [63:0]       way_mem [MAX_POINTS];
   logic [63:0]       rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;

   logic [ADDR_W-1:0] iss_ff, iss_in;
   logic              iss_done_ff, iss_done_in;
   logic              issue;
   logic [4:0]        v_ff, v_in;
   logic [ADDR_W-1:0] sidx_ff [5];
   logic [ADDR_W-1:0] sidx_in [5];
   logic [32:0]       ax_ff, ax_in, ay_ff, ay_in;
   logic [33:0]       hhx_ff, hhx_in, hhy_ff, hhy_in;
   logic [32:0]       hlx_ff, hlx_in, hly_ff, hly_in;
   logic [31:0]       llx_ff, llx_in, lly_ff, lly_in;
   logic [63:0]       sx_ff, sx_in, sy_ff, sy_in;
   logic [64:0]       key_ff, key_in;
   logic [64:0]       best_key_ff, best_key_in;
   logic [ADDR_W-1:0] best_ff, best_in;
   logic [ADDR_W-1:0] tgt_ff, tgt_in;

   logic signed [V_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [Z_W-1:0] cz_ff, cz_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  rotate_ff, rotate_in;

   mul_sel_type           mul_sel_ff, mul_sel_in;
   logic signed [41:0]    prod_ff, prod_in;
   logic signed [63:0]    acc_ff, acc_in;
   logic signed [M_W-1:0] xe_ff, xe_in, ye_ff, ye_in, d_ff, d_in;

   logic [47:0]      dn_ff, dn_in, yn_ff, yn_in;
   logic [32:0]      rem_ff, rem_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [4:0]       dcnt_ff, dcnt_in;
   logic [47:0]      num_ff, num_in;
   logic signed [STEER_W-1:0] steer_ff, steer_in;

   result_type res_ff, res_in;
   logic       res_v_ff, res_v_in;

   logic signed [32:0]    dx, dy;
   logic signed [V_W-1:0] xs, ys, ox, oy;
   logic signed [Z_W-1:0] at, rr;
   logic                  pos;
   logic [CNT_W-1:0]      base, tgt_full, last;
   logic signed [M_W-1:0] op48, axe, aye, yu;
   logic [23:0]           mlo;
   logic signed [23:0]    mhi;
   logic [39:0]           plo;
   logic signed [41:0]    phi;
   logic signed [63:0]    msum;
   logic signed [M_W-1:0] mres;
   logic [32:0]           r2;
   logic [47:0]           nprod, ld;
   logic signed [STEER_W-1:0] rmag;

   assign result       = res_ff;
   assign result_valid = res_v_ff;
   assign status.busy  = (state_ff != S_IDLE);
   assign status.count = count_ff;

   assign mlo   = op48[23:0];
   assign mhi   = op48[47:24];
   assign plo   = 40'(mlo) * 40'(INV_GAIN);
   assign phi   = 42'(mhi) * $signed(42'(INV_GAIN));
   assign nprod = 48'({cfg.wheelbase, 1'b0}) * 48'(q_ff);

   always_comb begin
      unique case (mul_sel_ff)
         MS_XE:   op48 = cx_ff[M_W-1:0];
         MS_YE:   op48 = cy_ff[M_W-1:0];
         default: op48 = cx_ff[M_W-1:0];
      endcase
   end

   // Nearest point scan pipeline.
   always_comb begin
      dx     = $signed({rd_data_ff[63], rd_data_ff[63:32]}) - $signed({item_ff.x[31], item_ff.x});
      dy     = $signed({rd_data_ff[31], rd_data_ff[31:0]}) - $signed({item_ff.y[31], item_ff.y});
      ax_in  = dx[32] ? 33'(-dx) : 33'(dx);
      ay_in  = dy[32] ? 33'(-dy) : 33'(dy);
      hhx_in = 34'(ax_ff[32:16]) * 34'(ax_ff[32:16]);
      hlx_in = 33'(ax_ff[32:16]) * 33'(ax_ff[15:0]);
      llx_in = 32'(ax_ff[15:0]) * 32'(ax_ff[15:0]);
      hhy_in = 34'(ay_ff[32:16]) * 34'(ay_ff[32:16]);
      hly_in = 33'(ay_ff[32:16]) * 33'(ay_ff[15:0]);
      lly_in = 32'(ay_ff[15:0]) * 32'(ay_ff[15:0]);
      sx_in  = {hhx_ff[31:0], 32'd0} + {14'd0, hlx_ff, 17'd0} + {32'd0, llx_ff};
      sy_in  = {hhy_ff[31:0], 32'd0} + {14'd0, hly_ff, 17'd0} + {32'd0, lly_ff};
      key_in = {1'b0, sx_ff} + {1'b0, sy_ff};
      sidx_in[0] = iss_ff;
      for (int k = 1; k < 5; k++) begin
         sidx_in[k] = sidx_ff[k-1];
      end
   end

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      count_in    = count_ff;
      iss_in      = iss_ff;
      iss_done_in = iss_done_ff;
      best_in     = best_ff;
      best_key_in = best_key_ff;
      tgt_in      = tgt_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      cz_in       = cz_ff;
      step_in     = step_ff;
      rotate_in   = rotate_ff;
      mul_sel_in  = mul_sel_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      xe_in       = xe_ff;
      ye_in       = ye_ff;
      d_in        = d_ff;
      dn_in       = dn_ff;
      yn_in       = yn_ff;
      rem_in      = rem_ff;
      q_in        = q_ff;
      dcnt_in     = dcnt_ff;
      num_in      = num_ff;
      steer_in    = steer_ff;
      res_in      = res_ff;
      res_v_in    = res_v_ff && !rsp_pop;
      q_pop       = 1'b0;
      mem_we      = 1'b0;
      mem_wa      = '0;
      rd_addr     = iss_ff;
      issue       = 1'b0;

      base     = (q_item.op == OP_RESTART) ? '0 : count_ff;
      last     = count_ff - 1'b1;
      tgt_full = CNT_W'(best_ff) + 1'b1;
      if (tgt_full > last) begin
         tgt_full = last;
      end

      xs  = cx_ff >>> step_ff;
      ys  = cy_ff >>> step_ff;
      at  = atan_step(step_ff);
      pos = rotate_ff ? !cz_ff[Z_W-1] : (cy_ff[V_W-1] || (cy_ff == '0));

      ox = ($signed({{28{rd_data_ff[63]}}, rd_data_ff[63:32]})
            - $signed({{28{item_ff.x[31]}}, item_ff.x})) <<< 8;
      oy = ($signed({{28{rd_data_ff[31]}}, rd_data_ff[31:0]})
            - $signed({{28{item_ff.y[31]}}, item_ff.y})) <<< 8;

      msum = acc_ff + (64'(prod_ff) <<< 24);
      mres = M_W'(msum >>> 16);
      axe  = xe_ff[M_W-1] ? -xe_ff : xe_ff;
      aye  = ye_ff[M_W-1] ? -ye_ff : ye_ff;
      yu   = (aye > d_ff) ? d_ff : aye;
      r2   = {rem_ff[31:0], (dcnt_ff == '0) ? yn_ff[0] : 1'b0};
      ld   = (d_ff[M_W-1:0] < ONE_Q24) ? ONE_Q24 : d_ff[M_W-1:0];
      rr   = (cz_ff + ROUND_HALF) >>> 18;
      if (rr > STEER_MAX) begin
         rr = STEER_MAX;
      end else if (rr[Z_W-1]) begin
         rr = '0;
      end
      rmag = rr[STEER_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               item_in = q_item;
               if (q_item.op == OP_POSE) begin
                  if (count_ff >= CNT_W'(MIN_POINTS)) begin
                     iss_in      = '0;
                     iss_done_in = 1'b0;
                     state_in    = S_SCAN;
                  end
               end else if (base < CNT_W'(MAX_POINTS)) begin
                  mem_we   = 1'b1;
                  mem_wa   = base[ADDR_W-1:0];
                  count_in = base + 1'b1;
               end else begin
                  count_in = base;
               end
            end
         end
         S_SCAN: begin
            if (!iss_done_ff) begin
               issue  = 1'b1;
               iss_in = iss_ff + 1'b1;
               if (CNT_W'(iss_ff) == last) begin
                  iss_done_in = 1'b1;
               end
            end else if (v_ff == '0) begin
               state_in = S_TGT;
            end
            if (v_ff[4] && ((sidx_ff[4] == '0) || (key_ff < best_key_ff))) begin
               best_in     = sidx_ff[4];
               best_key_in = key_ff;
            end
         end
         S_TGT: begin
            tgt_in   = tgt_full[ADDR_W-1:0];
            rd_addr  = tgt_full[ADDR_W-1:0];
            state_in = S_OFFS;
         end
         S_OFFS: begin
            cx_in     = item_ff.flip ? -ox : ox;
            cy_in     = item_ff.flip ? -oy : oy;
            cz_in     = Z_W'(item_ff.angle) <<< 18;
            step_in   = '0;
            rotate_in = 1'b1;
            state_in  = S_ROT;
         end
         S_ROT, S_VEC, S_ATAN: begin
            if (pos) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - at;
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + at;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               step_in = '0;
               if (state_ff == S_ROT) begin
                  mul_sel_in = MS_XE;
                  state_in   = S_ML;
               end else if (state_ff == S_VEC) begin
                  mul_sel_in = MS_D;
                  state_in   = S_ML;
               end else begin
                  state_in = S_RND;
               end
            end
         end
         S_ML: begin
            prod_in  = $signed({2'b00, plo});
            state_in = S_MH;
         end
         S_MH: begin
            acc_in   = 64'(prod_ff);
            prod_in  = phi;
            state_in = S_ME;
         end
         S_ME: begin
            unique case (mul_sel_ff)
               MS_XE: begin
                  xe_in      = mres;
                  mul_sel_in = MS_YE;
                  state_in   = S_ML;
               end
               MS_YE: begin
                  ye_in     = mres;
                  cx_in     = V_W'(axe);
                  cy_in     = V_W'(mres);
                  step_in   = '0;
                  rotate_in = 1'b0;
                  state_in  = S_VEC;
               end
               default: begin
                  d_in     = mres;
                  state_in = S_CHK;
               end
            endcase
         end
         S_CHK: begin
            if (!d_ff[M_W-1] && (d_ff != '0) && (ye_ff != '0)) begin
               dn_in    = d_ff[M_W-1:0];
               yn_in    = yu[M_W-1:0];
               state_in = S_NORM;
            end else begin
               steer_in = '0;
               state_in = S_OUT;
            end
         end
         S_NORM: begin
            if (dn_ff[47:32] != '0) begin
               dn_in = dn_ff >> 1;
               yn_in = yn_ff >> 1;
            end else begin
               rem_in   = {2'b00, yn_ff[31:1]};
               q_in     = '0;
               dcnt_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (r2 >= {1'b0, dn_ff[31:0]}) begin
               rem_in = r2 - {1'b0, dn_ff[31:0]};
               q_in   = {q_ff[Q_W-2:0], 1'b1};
            end else begin
               rem_in = r2;
               q_in   = {q_ff[Q_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == 5'(DIV_STEPS - 1)) begin
               state_in = S_NUM;
            end
         end
         S_NUM: begin
            num_in   = nprod;
            state_in = S_ATN0;
         end
         S_ATN0: begin
            cz_in = '0;
            if (num_ff == '0) begin
               state_in = S_RND;
            end else begin
               cx_in     = V_W'(ld) <<< 14;
               cy_in     = V_W'(num_ff);
               step_in   = '0;
               rotate_in = 1'b0;
               state_in  = S_ATAN;
            end
         end
         S_RND: begin
            steer_in = ye_ff[M_W-1] ? -rmag : rmag;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!res_v_ff || rsp_pop) begin
               res_in.steer = steer_ff;
               res_in.speed = cfg.speed;
               res_in.tgt   = TGT_W'(tgt_ff);
               res_v_in     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      v_in = {v_ff[3:0], issue};
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         way_mem[mem_wa] <= {q_item.x, q_item.y};
      end
      rd_data_ff <= way_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         v_ff     <= '0;
         res_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         v_ff     <= v_in;
         res_v_ff <= res_v_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      iss_ff      <= iss_in;
      iss_done_ff <= iss_done_in;
      sidx_ff     <= sidx_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      hhx_ff      <= hhx_in;
      hlx_ff      <= hlx_in;
      llx_ff      <= llx_in;
      hhy_ff      <= hhy_in;
      hly_ff      <= hly_in;
      lly_ff      <= lly_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      key_ff      <= key_in;
      best_ff     <= best_in;
      best_key_ff <= best_key_in;
      tgt_ff      <= tgt_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      step_ff     <= step_in;
      rotate_ff   <= rotate_in;
      mul_sel_ff  <= mul_sel_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      xe_ff       <= xe_in;
      ye_ff       <= ye_in;
      d_ff        <= d_in;
      dn_ff       <= dn_in;
      yn_ff       <= yn_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      dcnt_ff     <= dcnt_in;
      num_ff      <= num_in;
      steer_ff    <= steer_in;
      res_ff      <= res_in;
   end

endmodule

// File: src/pure_pursuit_steering.sv
// ----------------------------------------------------------------------------
// Pure pursuit steering
// Waypoints load one per cycle while the back end is idle; in the back end a
// pose update with n stored points scans one point per cycle, then up to 48
// CORDIC steps, three split multiplies and a 31-step divider follow.
// A four-item queue decouples input from the back end; one result register.
// Synchronous reset empties the queue and result, clears the point count and
// restores the register defaults; the waypoint store is not cleared.
// ----------------------------------------------------------------------------
module pure_pursuit_steering import pps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_type,
   input  logic        req_path_first,
   input  logic [31:0] req_coord_x,
   input  logic [31:0] req_coord_y,
   input  logic [15:0] req_heading,
   output logic        empty,
   input  logic        pop,
   output logic [13:0] rsp_steer_angle,
   output logic [15:0] rsp_speed_cmd,
   output logic [7:0]  rsp_target_index,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0] wheelbase_ff, wheelbase_in;
   logic [15:0] speed_ff, speed_in;
   cfg_type     cfg;
   item_type    front_item;
   item_type    q_item;
   logic        q_full;
   logic        q_empty;
   logic        q_pop;
   result_type  result;
   logic        result_valid;
   status_type  status;

   assign csr_ready     = 1'b1;
   assign cfg.wheelbase = wheelbase_ff;
   assign cfg.speed     = speed_ff;
   assign full          = q_full;
   assign empty         = !result_valid;
   assign rsp_steer_angle  = result.steer;
   assign rsp_speed_cmd    = result.speed;
   assign rsp_target_index = result.tgt;

   always_comb begin
      wheelbase_in = wheelbase_ff;
      speed_in     = speed_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WHEELBASE: wheelbase_in = csr_wdata;
            default:       speed_in     = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wheelbase_ff <= 16'd691;
         speed_ff     <= 16'd1024;
      end else begin
         wheelbase_ff <= wheelbase_in;
         speed_ff     <= speed_in;
      end
   end

   pps_front u_front (
      .req_type       (req_type),
      .req_path_first (req_path_first),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_heading    (req_heading),
      .item           (front_item)
   );

   pps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (q_pop),
      .pop_item  (q_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   pps_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .q_item       (q_item),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .rsp_pop      (pop && result_valid),
      .result       (result),
      .result_valid (result_valid),
      .status       (status)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      status.count <= CNT_W'(MAX_POINTS))
      else $error("Point count exceeds the store capacity.");

   a_steer_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ($signed(rsp_steer_angle) <= 14'sd6434 &&
                  $signed(rsp_steer_angle) >= -14'sd6434))
      else $error("Steering angle outside its range.");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (empty && !full && !status.busy))
      else $error("Block not cleared after reset.");

endmodule
